[design/sha256_stream_hasher_assert.svh]
// Assertion shorthands for the SHA-256 stream hasher.
// Each macro expects clk and arst_n in scope.
`ifndef SHA256_STREAM_HASHER_ASSERT_SVH
`define SHA256_STREAM_HASHER_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define SHASH_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("shash: same-cycle check failed");

// Check that cons holds in the cycle after ante.
`define SHASH_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("shash: next-cycle check failed");

`endif

[design/shash_pkg.sv]
package shash_pkg;

	typedef logic [31:0] word_t;

	// Byte value that opens the padding, and the offset where the length starts
	localparam logic [7:0] PAD_BYTE   = 8'h80;
	localparam logic [5:0] LEN_OFFSET = 6'd56;
	localparam logic [5:0] LAST_POS   = 6'd63;
	localparam logic [2:0] LAST_IDX   = 3'd7;

	localparam word_t HASH_IV [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam word_t ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	// Control from the stream front end to the compression core
	typedef struct packed {
		logic start;
		logic init;
	} core_ctrl_t;

	// Status back from the compression core
	typedef struct packed {
		logic busy;
		logic done;
	} core_stat_t;

	typedef enum logic [1:0] {
		CS_IDLE,
		CS_ROUND,
		CS_ADD
	} core_state_t;

	typedef enum logic [1:0] {
		ST_FILL,
		ST_COMP,
		ST_PAD,
		ST_OUT
	} top_state_t;

	function automatic word_t rotr(input word_t x, input int unsigned n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction

	function automatic word_t big_sigma0(input word_t x);
		big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
	endfunction

	function automatic word_t big_sigma1(input word_t x);
		big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
	endfunction

	function automatic word_t small_sigma0(input word_t x);
		small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic word_t small_sigma1(input word_t x);
		small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction

endpackage

[design/sha256_stream_hasher.sv]
// Byte-stream SHA-256. Each accepted word carries at most one message byte
// and may close the message; a closed message yields eight digest words,
// most significant first, the eighth marked by last_word. Every full 64-byte
// block holds off input while the compression core runs its 64 rounds, one
// per cycle, and folds the result into the hash. Closing a message adds the
// padding bytes (up to 64, or 72 when the length spills into an extra block),
// a compression per padded block, and the delivery of the digest words.
module sha256_stream_hasher
	import shash_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_stall,
	input  logic [7:0]  data_byte,
	input  logic        byte_valid,
	input  logic        end_of_message,
	output logic        word_valid,
	input  logic        word_stall,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word
);

	top_state_t       state_q, state_d;
	logic [5:0]       fill_q;
	logic [60:0]      count_q;
	logic [511:0]     blk_q;
	logic [2:0]       idx_q;
	logic             pad_q, pad80_q, wrap_q, final_q;
	logic             item_acc, word_acc, push_en, blk_full, msg_done;
	logic [7:0]       push_byte;
	logic [63:0]      len_bits, len_shift;
	core_ctrl_t       core_ctrl;
	core_stat_t       core_stat;
	logic [7:0][31:0] hash;

	assign item_acc = item_valid && !item_stall;
	assign word_acc = word_valid && !word_stall;
	assign msg_done = word_acc && (idx_q == LAST_IDX);

	// Pick the length byte for the current fill position
	assign len_bits  = {count_q, 3'b000};
	assign len_shift = len_bits >> {LAST_IDX - fill_q[2:0], 3'b000};

	// Choose the byte to push: from the stream, or padding
	always_comb begin
		push_en   = 1'b0;
		push_byte = data_byte;
		if (state_q == ST_FILL) begin
			push_en = item_acc && byte_valid;
		end else if (state_q == ST_PAD) begin
			push_en = 1'b1;
			if (!pad80_q) begin
				push_byte = PAD_BYTE;
			end else if (fill_q >= LEN_OFFSET && !wrap_q) begin
				push_byte = len_shift[7:0];
			end else begin
				push_byte = '0;
			end
		end
	end

	assign blk_full = push_en && (fill_q == LAST_POS);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_FILL: begin
				if (item_acc) begin
					if (blk_full) state_d = ST_COMP;
					else if (end_of_message) state_d = ST_PAD;
				end
			end
			ST_PAD: if (blk_full) state_d = ST_COMP;
			ST_COMP: begin
				if (core_stat.done) begin
					if (final_q) state_d = ST_OUT;
					else if (pad_q) state_d = ST_PAD;
					else state_d = ST_FILL;
				end
			end
			ST_OUT: if (msg_done) state_d = ST_FILL;
			default: state_d = ST_FILL;
		endcase
	end

	// Handshake and core control outputs
	always_comb begin
		item_stall     = (state_q != ST_FILL);
		word_valid     = (state_q == ST_OUT);
		word_index     = idx_q;
		last_word      = (idx_q == LAST_IDX);
		digest_word    = hash[idx_q];
		core_ctrl.start = blk_full;
		core_ctrl.init  = msg_done;
	end

	// Control state and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_FILL;
			fill_q  <= '0;
			count_q <= '0;
			idx_q   <= '0;
			pad_q   <= 1'b0;
			pad80_q <= 1'b0;
			wrap_q  <= 1'b0;
			final_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (push_en) begin
				fill_q <= fill_q + 6'd1;
			end
			if (word_acc) begin
				idx_q <= idx_q + 3'd1;
			end
			if (msg_done) begin
				count_q <= '0;
				pad_q   <= 1'b0;
				pad80_q <= 1'b0;
				final_q <= 1'b0;
			end else begin
				if (state_q == ST_FILL && item_acc && byte_valid) begin
					count_q <= count_q + 61'd1;
				end
				if (state_q == ST_FILL && item_acc && end_of_message) begin
					pad_q <= 1'b1;
				end
				if (state_q == ST_PAD && !pad80_q) begin
					pad80_q <= 1'b1;
				end
				// last length byte closes the final block
				if (state_q == ST_PAD && blk_full && pad80_q && !wrap_q) begin
					final_q <= 1'b1;
				end
			end
			// 0x80 landed in the length area: zero to block end, length goes in the next
			if (blk_full) begin
				wrap_q <= 1'b0;
			end else if (state_q == ST_PAD && !pad80_q && fill_q >= LEN_OFFSET) begin
				wrap_q <= 1'b1;
			end
		end
	end

	// Shift bytes into the block buffer, first byte ends up most significant
	always_ff @(posedge clk) begin
		if (push_en) begin
			blk_q <= {blk_q[503:0], push_byte};
		end
	end

	shash_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (core_ctrl),
		.block  ({blk_q[503:0], push_byte}),
		.stat   (core_stat),
		.hash   (hash)
	);

`include "sha256_stream_hasher_assert.svh"

	`SHASH_ASSERT_NOW(a_start_free, core_ctrl.start, !core_stat.busy)
	`SHASH_ASSERT_NOW(a_out_empty, word_valid, fill_q == 6'd0)
	`SHASH_ASSERT_NEXT(a_back_to_fill, msg_done, state_q == ST_FILL)
	`SHASH_ASSERT_NOW(a_pad_not_final, state_q == ST_PAD, !final_q)

endmodule

[design/shash_core.sv]
module shash_core
	import shash_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  core_ctrl_t          ctrl,
	input  logic [511:0]        block,
	output core_stat_t          stat,
	output logic [7:0][31:0]    hash
);

	core_state_t state_q, state_d;
	logic [5:0]  rnd_q;
	word_t       hash_q [8];
	word_t       v_q [8];
	word_t       w_q [16];
	word_t       t1, t2, w_new, ch, maj;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			CS_IDLE:  if (ctrl.start) state_d = CS_ROUND;
			CS_ROUND: if (rnd_q == LAST_POS) state_d = CS_ADD;
			CS_ADD:   state_d = CS_IDLE;
			default:  state_d = CS_IDLE;
		endcase
	end

	// Status outputs
	always_comb begin
		stat.busy = (state_q != CS_IDLE);
		stat.done = (state_q == CS_ADD);
	end

	always_comb begin
		for (int j = 0; j < 8; j++) begin
			hash[j] = hash_q[j];
		end
	end

	// One round of the compression function and one schedule word
	always_comb begin
		ch    = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
		maj   = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
		t1    = v_q[7] + big_sigma1(v_q[4]) + ch + ROUND_K[rnd_q] + w_q[0];
		t2    = big_sigma0(v_q[0]) + maj;
		w_new = w_q[0] + small_sigma0(w_q[1]) + w_q[9] + small_sigma1(w_q[14]);
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CS_IDLE;
			rnd_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == CS_ROUND) begin
				rnd_q <= rnd_q + 6'd1;
			end else begin
				rnd_q <= '0;
			end
		end
	end

	// Hash words: load the initial values, or fold in the finished block
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < 8; j++) begin
				hash_q[j] <= HASH_IV[j];
			end
		end else if (state_q == CS_ADD) begin
			for (int j = 0; j < 8; j++) begin
				hash_q[j] <= hash_q[j] + v_q[j];
			end
		end else if (state_q == CS_IDLE && ctrl.init) begin
			for (int j = 0; j < 8; j++) begin
				hash_q[j] <= HASH_IV[j];
			end
		end
	end

	// Working variables and schedule window
	always_ff @(posedge clk) begin
		if (state_q == CS_IDLE && ctrl.start) begin
			for (int j = 0; j < 8; j++) begin
				v_q[j] <= hash_q[j];
			end
			for (int j = 0; j < 16; j++) begin
				w_q[j] <= block[511 - 32 * j -: 32];
			end
		end else if (state_q == CS_ROUND) begin
			v_q[0] <= t1 + t2;
			v_q[1] <= v_q[0];
			v_q[2] <= v_q[1];
			v_q[3] <= v_q[2];
			v_q[4] <= v_q[3] + t1;
			v_q[5] <= v_q[4];
			v_q[6] <= v_q[5];
			v_q[7] <= v_q[6];
			for (int j = 0; j < 15; j++) begin
				w_q[j] <= w_q[j + 1];
			end
			w_q[15] <= w_new;
		end
	end

`include "sha256_stream_hasher_assert.svh"

	`SHASH_ASSERT_NOW(a_start_idle, ctrl.start, state_q == CS_IDLE)
	`SHASH_ASSERT_NEXT(a_done_idle, stat.done, state_q == CS_IDLE)
	`SHASH_ASSERT_NOW(a_rnd_idle, state_q != CS_ROUND, rnd_q == 6'd0)

endmodule

[tb/sv/sha256_digest_checker.sv]
`timescale 1ns / 100ps

// Follows the input and digest channels of the stream hasher, keeps a running
// SHA-256 of every accepted byte and compares each digest word as it leaves.
module sha256_digest_checker
	import shash_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	input  logic        item_stall,
	input  logic [7:0]  data_byte,
	input  logic        byte_valid,
	input  logic        end_of_message,
	input  logic        word_valid,
	input  logic        word_stall,
	input  logic [31:0] digest_word,
	input  logic [2:0]  word_index,
	input  logic        last_word,
	output int          error_count,
	output int          words_due,
	output int          words_checked
);

	typedef struct packed {
		logic [31:0] value;
		logic [2:0]  index;
		logic        last;
	} digest_entry_t;

	// Running hash of the current message
	word_t         chain_words [8];
	logic [7:0]    block_bytes [64];
	int unsigned   block_fill;
	logic [60:0]   msg_len_bytes;
	digest_entry_t digest_due [$];
	int            errors;
	int            checked;

	function automatic word_t rot_right(input word_t x, input int unsigned n);
		return (x >> n) | (x << (32 - n));
	endfunction

	// Fold the 64 buffered bytes into the chaining value
	function automatic void compress_block();
		word_t sched [64];
		word_t v [8];
		word_t s0;
		word_t s1;
		word_t t1;
		word_t t2;
		for (int i = 0; i < 16; i++)
			sched[i] = {block_bytes[4*i], block_bytes[4*i+1],
				block_bytes[4*i+2], block_bytes[4*i+3]};
		for (int i = 16; i < 64; i++) begin
			s0 = rot_right(sched[i-15], 7) ^ rot_right(sched[i-15], 18) ^ (sched[i-15] >> 3);
			s1 = rot_right(sched[i-2], 17) ^ rot_right(sched[i-2], 19) ^ (sched[i-2] >> 10);
			sched[i] = sched[i-16] + s0 + sched[i-7] + s1;
		end
		v = chain_words;
		for (int i = 0; i < 64; i++) begin
			t1 = v[7] + (rot_right(v[4], 6) ^ rot_right(v[4], 11) ^ rot_right(v[4], 25))
				+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[i] + sched[i];
			t2 = (rot_right(v[0], 2) ^ rot_right(v[0], 13) ^ rot_right(v[0], 22))
				+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6];
			v[6] = v[5];
			v[5] = v[4];
			v[4] = v[3] + t1;
			v[3] = v[2];
			v[2] = v[1];
			v[1] = v[0];
			v[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++)
			chain_words[i] += v[i];
	endfunction

	function automatic void absorb_byte(input logic [7:0] b);
		block_bytes[block_fill] = b;
		block_fill++;
		if (block_fill == 64) begin
			compress_block();
			block_fill = 0;
		end
	endfunction

	function automatic void restart_message();
		chain_words   = HASH_IV;
		block_fill    = 0;
		msg_len_bytes = '0;
	endfunction

	// Pad, append the bit length, queue the eight digest words and start afresh
	function automatic void close_message();
		logic [63:0]   bit_len;
		digest_entry_t entry;
		bit_len = {msg_len_bytes, 3'b000};
		absorb_byte(PAD_BYTE);
		while (block_fill != LEN_OFFSET)
			absorb_byte(8'h00);
		for (int i = 0; i < 8; i++)
			absorb_byte(bit_len[63-8*i -: 8]);
		for (int i = 0; i < 8; i++) begin
			entry.value = chain_words[i];
			entry.index = i[2:0];
			entry.last  = (i[2:0] == LAST_IDX);
			digest_due.push_back(entry);
		end
		restart_message();
	endfunction

	function automatic void check_field(input string field, input logic [31:0] want,
		input logic [31:0] got);
		if (got !== want) begin
			$display("%0t ns: %s mismatch, expected %h, got %h", $time, field, want, got);
			errors++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		digest_entry_t want;
		if (!arst_n) begin
			restart_message();
			digest_due.delete();
			errors        = 0;
			checked       = 0;
			error_count   <= 0;
			words_due     <= 0;
			words_checked <= 0;
		end else begin
			// Compare a delivered digest word with the oldest one due
			if (word_valid && !word_stall) begin
				if (digest_due.size() == 0) begin
					$display("%0t ns: unexpected digest word, expected none, got %h idx %0d",
						$time, digest_word, word_index);
					errors++;
				end else begin
					want = digest_due.pop_front();
					check_field("digest_word", want.value, digest_word);
					check_field("word_index", 32'(want.index), 32'(word_index));
					check_field("last_word", 32'(want.last), 32'(last_word));
					checked++;
				end
			end
			// Advance the running hash on an accepted input word
			if (item_valid && !item_stall) begin
				if (byte_valid) begin
					absorb_byte(data_byte);
					msg_len_bytes++;
				end
				if (end_of_message)
					close_message();
			end
			error_count   <= errors;
			words_due     <= digest_due.size();
			words_checked <= checked;
		end
	end

endmodule

[tb/sv/tb_sha256_stream_hasher.sv]
`timescale 1ns / 100ps

module tb_sha256_stream_hasher;

	localparam int LIMIT_CYCLES = 200000;
	localparam int DRAIN_CYCLES = 200;

	logic        clk            = 1'b0;
	logic        arst_n         = 1'b0;
	logic        item_valid     = 1'b0;
	logic [7:0]  data_byte      = 8'h00;
	logic        byte_valid     = 1'b0;
	logic        end_of_message = 1'b0;
	logic        word_stall     = 1'b0;
	logic        item_stall;
	logic        word_valid;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;

	int error_count;
	int words_due;
	int words_checked;
	int cycle_count = 0;
	int idle_pct    = 0;
	int stall_pct   = 0;
	int items_sent  = 0;
	int bytes_sent  = 0;
	int idle_sent   = 0;
	int msgs_sent   = 0;

	sha256_stream_hasher u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.item_valid     (item_valid),
		.item_stall     (item_stall),
		.data_byte      (data_byte),
		.byte_valid     (byte_valid),
		.end_of_message (end_of_message),
		.word_valid     (word_valid),
		.word_stall     (word_stall),
		.digest_word    (digest_word),
		.word_index     (word_index),
		.last_word      (last_word)
	);

	sha256_digest_checker u_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.item_valid     (item_valid),
		.item_stall     (item_stall),
		.data_byte      (data_byte),
		.byte_valid     (byte_valid),
		.end_of_message (end_of_message),
		.word_valid     (word_valid),
		.word_stall     (word_stall),
		.digest_word    (digest_word),
		.word_index     (word_index),
		.last_word      (last_word),
		.error_count    (error_count),
		.words_due      (words_due),
		.words_checked  (words_checked)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Stall the digest side at random
	always @(posedge clk)
		word_stall <= ($urandom_range(99) < stall_pct);

	// Bound the run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("Timed out after %0d cycles with %0d digest words due", cycle_count,
				words_due);
			$display("FAILURE");
			$finish;
		end
	end

	task automatic set_idling(input int mix);
		case (mix)
			0: begin
				idle_pct = 0;
				stall_pct <= 0;
			end
			1: begin
				idle_pct = 50;
				stall_pct <= 0;
			end
			2: begin
				idle_pct = 0;
				stall_pct <= 50;
			end
			default: begin
				idle_pct = 33;
				stall_pct <= 33;
			end
		endcase
	endtask

	// Offer one word, with random gaps ahead of it, and hold it until taken
	task automatic send_item(input logic [7:0] value, input logic has_byte,
		input logic closes);
		while ($urandom_range(99) < idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid     <= 1'b1;
		data_byte      <= value;
		byte_valid     <= has_byte;
		end_of_message <= closes;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		if (has_byte || closes)
			items_sent++;
		else
			idle_sent++;
		if (has_byte)
			bytes_sent++;
		if (closes)
			msgs_sent++;
	endtask

	// Drop valid and hold off until every digest word has come out
	task automatic wait_for_digests();
		item_valid <= 1'b0;
		@(posedge clk);
		while (words_due != 0)
			@(posedge clk);
	endtask

	// Random message bytes with stray empty words; close on the last byte or apart
	task automatic send_message(input int unsigned len);
		bit close_on_byte;
		close_on_byte = (len != 0) && ($urandom_range(1) == 1);
		set_idling(msgs_sent % 4);
		for (int unsigned n = 0; n < len; n++) begin
			if ($urandom_range(7) == 0)
				send_item(8'($urandom_range(255)), 1'b0, 1'b0);
			send_item(8'($urandom_range(255)), 1'b1, close_on_byte && (n == len - 1));
		end
		if (!close_on_byte)
			send_item(8'($urandom_range(255)), 1'b0, 1'b1);
	endtask

	initial begin
		int unsigned len;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty word, empty message, closing with and without a byte
		set_idling(0);
		send_item(8'hA5, 1'b0, 1'b0);
		send_item(8'h3C, 1'b0, 1'b1);
		send_item(8'h61, 1'b1, 1'b0);
		send_item(8'h62, 1'b1, 1'b0);
		send_item(8'h63, 1'b1, 1'b1);
		send_item(8'hFF, 1'b1, 1'b0);
		send_item(8'h00, 1'b0, 1'b1);
		send_item(8'h00, 1'b1, 1'b1);
		send_item(8'h00, 1'b0, 1'b1);
		send_item(8'hFF, 1'b0, 1'b1);
		wait_for_digests();

		// Padding that just fits, padding that spills, an exactly full block
		send_message(55);
		send_message(56);
		send_message(64);
		wait_for_digests();

		// Random messages, mostly short, some around the padding boundaries
		while (items_sent < 200 || msgs_sent < 12) begin
			if ($urandom_range(3) == 0) begin
				case ($urandom_range(6))
					0:       len = 0;
					1:       len = 55;
					2:       len = 56;
					3:       len = 57;
					4:       len = 63;
					5:       len = 64;
					default: len = 65;
				endcase
			end else begin
				len = $urandom_range(24);
			end
			send_message(len);
			if (msgs_sent % 5 == 0)
				wait_for_digests();
		end
		wait_for_digests();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Hashed %0d messages from %0d bytes in %0d words plus %0d empty words;",
			msgs_sent, bytes_sent, items_sent, idle_sent);
		$display("compared %0d digest words under four mixes of gaps and stalls.",
			words_checked);
		if (error_count == 0 && words_due == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

[sha256_stream_hasher.f]
+incdir+design
design/shash_pkg.sv
design/shash_core.sv
design/sha256_stream_hasher.sv
tb/sv/sha256_digest_checker.sv
tb/sv/tb_sha256_stream_hasher.sv
